### hdl/brf_pkg.sv
// Shared types, codes and default sizes for the broadcast ring FIFO.
`default_nettype none
package brf_pkg;

  localparam int SLOTS_DEF        = 16;
  localparam int MAX_READERS_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int OPCODE_W  = 2;
  localparam int KIND_W    = 3;
  localparam int CURSOR_W  = 4;
  localparam int PUB_W     = 16;
  localparam int WORD_W    = 64;
  localparam int STAMP_W   = 32;
  localparam int READS_W   = 5;
  localparam logic [READS_W-1:0] READS_MAX = 5'd31;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_SUB   = 2'd1,
    OP_DEQ   = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ_ACK  = 3'd0,
    KIND_SUB_ACK  = 3'd1,
    KIND_DEQ_DATA = 3'd2,
    KIND_ARCHIVE  = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DQ_READ,
    ST_DR_READ,
    ST_EMIT,
    ST_ARCH,
    ST_DR_EMIT
  } state_t;

  typedef struct packed {
    kind_t                kind;
    logic                 ok;
    logic [CURSOR_W-1:0]  cursor;
    logic [WORD_W-1:0]    payload;
    logic [PUB_W-1:0]     publisher;
    logic [STAMP_W-1:0]   stamp;
    logic                 last;
  } result_t;

endpackage
`default_nettype wire

### hdl/brf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/brf_out_stage.sv
// Output register between the ring controller and the result stream.
`default_nettype none
module brf_out_stage import brf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  res_valid,
  output logic                       res_ready,
  input  wire result_t               res,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // ok, cursor_out, payload_out, publisher_out, stamp_out, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // kind
  output logic [KIND_W-1:0]          m_axis_tuser,
  output logic                       m_axis_tlast
);

  logic    vld;
  result_t held;

  assign res_ready = !vld || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (res_ready) begin
      vld <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = vld;
  assign m_axis_tdata  = {3'b000, held.stamp, held.publisher, held.payload,
                          held.cursor, held.ok};
  assign m_axis_tuser  = held.kind;
  assign m_axis_tlast  = held.last;

endmodule
`default_nettype wire

### hdl/broadcast_ring_fifo_core.sv
// Top level of the broadcast ring FIFO: controller, slot memory and output register.
// Input is taken only when idle. Enqueue, subscribe and a refused dequeue register their
// result at acceptance and pass it to the output register from the emit state. A served
// dequeue reads the slot, writes back its read count, emits the data and, if the slot is
// archived, an archive result. A drain emits each archived slot, then the done marker.
// Synchronous reset clears both heads and the reader count; the slot memory is not cleared.
`default_nettype none
module broadcast_ring_fifo_core import brf_pkg::*; #(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int MAX_READERS  = MAX_READERS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // publisher_id, payload_in, time_now, cursor_in, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic [OPCODE_W-1:0]   s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // ok, cursor_out, payload_out, publisher_out, stamp_out, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // kind
  output logic [KIND_W-1:0]          m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int RT_W    = $clog2(MAX_READERS + 1);
  localparam int EQ_W    = (RT_W > READS_W) ? RT_W : READS_W;
  localparam int MOD_LIM = (SLOTS > 15) ? 16 : SLOTS;
  localparam int RAM_W   = READS_W + STAMP_W + PUB_W + PAYLOAD_BITS;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [CURSOR_W-1:0] to_cursor(input logic [IDX_W-1:0] i);
    logic [IDX_W+CURSOR_W-1:0] t;
    t = {{CURSOR_W{1'b0}}, i};
    return t[CURSOR_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] cursor_idx(input logic [CURSOR_W-1:0] c);
    logic [CURSOR_W:0]         v;
    logic [IDX_W+CURSOR_W:0]   t;
    v = {1'b0, c};
    for (int k = 0; k < 8; k++) begin
      if (v >= (CURSOR_W+1)'(MOD_LIM)) begin
        v = v - (CURSOR_W+1)'(MOD_LIM);
      end
    end
    t = {{IDX_W{1'b0}}, v};
    return t[IDX_W-1:0];
  endfunction

  op_t                   in_op;
  logic [PUB_W-1:0]      in_pub;
  logic [WORD_W-1:0]     in_pay;
  logic [STAMP_W-1:0]    in_time;
  logic [IDX_W-1:0]      in_idx;

  assign in_op   = op_t'(s_axis_tuser);
  assign in_pub  = s_axis_tdata[15:0];
  assign in_pay  = s_axis_tdata[79:16];
  assign in_time = s_axis_tdata[111:80];
  assign in_idx  = cursor_idx(s_axis_tdata[115:112]);

  state_t            state, state_next;
  logic [IDX_W-1:0]  read_head, write_head, cur_idx;
  logic [RT_W-1:0]   reader_total;
  logic              arch_pend;
  result_t           res_q, res;
  logic              res_valid, res_ready;
  logic              s_accept, emit_done;

  logic [PAYLOAD_BITS-1:0] slot_pay;
  logic [PUB_W-1:0]        slot_pub;
  logic [STAMP_W-1:0]      slot_stamp;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [PUB_W-1:0]        rd_pub;
  logic [STAMP_W-1:0]      rd_stamp;
  logic [READS_W-1:0]      rd_reads, reads_new;
  logic                    arch_hit;
  logic                    wr_full, deq_miss, drain_empty;
  logic [IDX_W-1:0]        rh_next;

  assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
  assign rd_pub   = ram_rdata[PAYLOAD_BITS +: PUB_W];
  assign rd_stamp = ram_rdata[PAYLOAD_BITS+PUB_W +: STAMP_W];
  assign rd_reads = ram_rdata[RAM_W-1 -: READS_W];

  assign reads_new   = (rd_reads == READS_MAX) ? rd_reads : rd_reads + 1'b1;
  assign arch_hit    = (EQ_W'(reads_new) == EQ_W'(reader_total));
  assign wr_full     = (idx_next(write_head) == read_head);
  assign deq_miss    = (in_idx == write_head);
  assign drain_empty = (read_head == write_head);
  assign rh_next     = idx_next(read_head);

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign emit_done = res_valid && res_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (in_op == OP_DEQ && !deq_miss) begin
            state_next = ST_DQ_READ;
          end else if (in_op == OP_DRAIN && !drain_empty) begin
            state_next = ST_DR_READ;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DQ_READ: state_next = ST_EMIT;
      ST_DR_READ: state_next = ST_DR_EMIT;
      ST_EMIT: begin
        if (emit_done) begin
          state_next = arch_pend ? ST_ARCH : ST_IDLE;
        end
      end
      ST_ARCH: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_DR_EMIT: begin
        if (emit_done) begin
          state_next = (rh_next == write_head) ? ST_EMIT : ST_DR_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    res_valid     = 1'b0;
    res           = res_q;
    ram_we        = 1'b0;
    ram_waddr     = write_head;
    ram_wdata     = {READS_W'(0), in_time, in_pub, in_pay[PAYLOAD_BITS-1:0]};
    ram_re        = 1'b0;
    ram_raddr     = in_idx;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ram_we = (in_op == OP_ENQ) && !wr_full;
          if (in_op == OP_DEQ) begin
            ram_re = !deq_miss;
          end else if (in_op == OP_DRAIN) begin
            ram_re    = !drain_empty;
            ram_raddr = read_head;
          end
        end
      end
      ST_DQ_READ: begin
        ram_we    = 1'b1;
        ram_waddr = cur_idx;
        ram_wdata = {reads_new, rd_stamp, rd_pub, rd_pay};
      end
      ST_EMIT: begin
        res_valid = 1'b1;
      end
      ST_ARCH, ST_DR_EMIT: begin
        res_valid     = 1'b1;
        res.kind      = KIND_ARCHIVE;
        res.ok        = 1'b0;
        res.cursor    = to_cursor(cur_idx);
        res.payload   = WORD_W'(slot_pay);
        res.publisher = slot_pub;
        res.stamp     = slot_stamp;
        res.last      = (state == ST_ARCH);
        if (state == ST_DR_EMIT && res_ready && rh_next != write_head) begin
          ram_re    = 1'b1;
          ram_raddr = rh_next;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      read_head    <= '0;
      write_head   <= '0;
      reader_total <= '0;
      arch_pend    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            arch_pend <= 1'b0;
            if (in_op == OP_ENQ && !wr_full) begin
              write_head <= idx_next(write_head);
            end
            if (in_op == OP_SUB && reader_total != RT_W'(MAX_READERS)) begin
              reader_total <= reader_total + 1'b1;
            end
          end
        end
        ST_DQ_READ: begin
          arch_pend <= arch_hit;
          if (arch_hit) begin
            read_head <= rh_next;
          end
        end
        ST_DR_EMIT: begin
          if (emit_done) begin
            read_head <= rh_next;
            arch_pend <= 1'b0;
          end
        end
        default: begin
          arch_pend <= arch_pend;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          cur_idx         <= (in_op == OP_DRAIN) ? read_head : in_idx;
          res_q.payload   <= '0;
          res_q.publisher <= '0;
          res_q.stamp     <= '0;
          res_q.last      <= 1'b1;
          case (in_op)
            OP_ENQ: begin
              res_q.kind   <= KIND_ENQ_ACK;
              res_q.ok     <= !wr_full;
              res_q.cursor <= to_cursor(write_head);
            end
            OP_SUB: begin
              res_q.kind   <= KIND_SUB_ACK;
              res_q.ok     <= 1'b0;
              res_q.cursor <= to_cursor(read_head);
            end
            OP_DEQ: begin
              res_q.kind   <= KIND_DEQ_DATA;
              res_q.ok     <= 1'b0;
              res_q.cursor <= to_cursor(in_idx);
            end
            default: begin
              res_q.kind   <= KIND_DONE;
              res_q.ok     <= 1'b0;
              res_q.cursor <= to_cursor(read_head);
            end
          endcase
        end
      end
      ST_DQ_READ, ST_DR_READ: begin
        slot_pay   <= rd_pay;
        slot_pub   <= rd_pub;
        slot_stamp <= rd_stamp;
        if (state == ST_DQ_READ) begin
          res_q.kind      <= KIND_DEQ_DATA;
          res_q.ok        <= 1'b1;
          res_q.cursor    <= to_cursor(idx_next(cur_idx));
          res_q.payload   <= WORD_W'(rd_pay);
          res_q.publisher <= rd_pub;
          res_q.stamp     <= rd_stamp;
          res_q.last      <= !arch_hit;
        end
      end
      ST_DR_EMIT: begin
        if (emit_done) begin
          cur_idx         <= rh_next;
          res_q.kind      <= KIND_DONE;
          res_q.ok        <= 1'b0;
          res_q.cursor    <= to_cursor(rh_next);
          res_q.payload   <= '0;
          res_q.publisher <= '0;
          res_q.stamp     <= '0;
          res_q.last      <= 1'b1;
        end
      end
      default: begin
        cur_idx <= cur_idx;
      end
    endcase
  end

  brf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brf_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A refused enqueue must leave the write head where it was.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    s_accept && in_op == OP_ENQ && wr_full |=> $stable(write_head))
    else $error("write head moved on a full ring");

  // The done marker of a drain is only shown once the ring is empty.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && res_q.kind == KIND_DONE |-> read_head == write_head)
    else $error("drain finished with slots left");

  // The reader count never passes its maximum.
  a_readers_cap: assert property (@(posedge clk) disable iff (rst)
    reader_total <= RT_W'(MAX_READERS))
    else $error("reader count above maximum");

  // The slot memory is never read and written in the same cycle.
  a_ram_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("slot memory read and write collide");

endmodule
`default_nettype wire
